// ===== design/rc_throttle_ramp_motor_control_top_assert.svh =====
// Assertion macros for the throttle ramp block.
// Needs signals named clock and reset in the including module.
`ifndef RC_THROTTLE_RAMP_MOTOR_CONTROL_TOP_ASSERT_SVH
`define RC_THROTTLE_RAMP_MOTOR_CONTROL_TOP_ASSERT_SVH

// check an implication on every clock edge outside reset
`define RCTR_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// check that two conditions agree outside reset while a gate is high
`define RCTR_ASSERT_IFF(lbl, gate, lhs, rhs, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (gate) |-> ((lhs) == (rhs))) \
      else $error(msg);

`endif

// ===== design/rctr_pkg.sv =====
// Shared types, codes and mapping functions of the throttle ramp block.
// No dependencies.
package rctr_pkg;

   localparam int RCTR_TIMER_BITS_DEFAULT = 11;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_USE_DIRECTION      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_TIMEOUT_MS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_MS            = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUNCH_PCT          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_MID_US         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_BAND_US        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_CHANGE_MAX_PCT = 3'd6;

   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_THROTTLE  = 2'd1;
   localparam logic [1:0] OP_DIRECTION = 2'd2;

   localparam logic [15:0] WIDTH_MIN = 16'd800;
   localparam logic [15:0] WIDTH_MAX = 16'd2200;
   localparam logic [11:0] MAP_LOW   = 12'd1000;
   localparam logic [11:0] MAP_HIGH  = 12'd2000;
   localparam logic [6:0]  RAMP_STEP = 7'd2;
   localparam logic [6:0]  PCT_FULL  = 7'd100;
   localparam logic [11:0] WIDTH_RESET = 12'd1500;

   localparam int FAILSAFE_W = 10;
   localparam int STEP_W     = 8;

   typedef struct packed {
      logic        use_direction;
      logic [9:0]  loss_timeout_ms;
      logic [7:0]  step_ms;
      logic [6:0]  punch_pct;
      logic [11:0] dir_mid_us;
      logic [9:0]  dir_band_us;
      logic [6:0]  dir_change_max_pct;
   } rctr_cfg_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic       motor_enable;
      logic       dir_cw;
      logic [6:0] duty_pct;
      logic [6:0] target_pct;
      logic       running;
      logic       failsafe_active;
   } rctr_rsp_type;

   // (w - 1000) / 10 through x * 205 >> 11, exact for x below 1029
   function automatic logic [6:0] target_of(input logic [11:0] w);
      logic [9:0]  x;
      logic [17:0] p;
      x = 10'(w - MAP_LOW);
      p = 18'(x) * 18'd205;
      if (w <= MAP_LOW) begin
         return 7'd0;
      end else if (w >= MAP_HIGH) begin
         return PCT_FULL;
      end
      return p[17:11];
   endfunction

   // pct * 255 / 100 through pct * 1336965 >> 19
   function automatic logic [7:0] pwm_of(input logic [6:0] pct);
      logic [6:0]  c;
      logic [27:0] p;
      c = (pct > PCT_FULL) ? PCT_FULL : pct;
      p = 28'(c) * 28'd1336965;
      return p[26:19];
   endfunction

endpackage

// ===== design/rctr_cfg_regs.sv =====
// Configuration register file of the throttle ramp block.
// Depends on rctr_pkg.
module rctr_cfg_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [rctr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rctr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output rctr_pkg::rctr_cfg_type          cfg
);
   import rctr_pkg::*;

   rctr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_USE_DIRECTION:      cfg_in.use_direction      = csr_write_data[0];
            CSR_LOSS_TIMEOUT_MS:    cfg_in.loss_timeout_ms    = csr_write_data[9:0];
            CSR_STEP_MS:            cfg_in.step_ms            = csr_write_data[7:0];
            CSR_PUNCH_PCT:          cfg_in.punch_pct          = csr_write_data[6:0];
            CSR_DIR_MID_US:         cfg_in.dir_mid_us         = csr_write_data[11:0];
            CSR_DIR_BAND_US:        cfg_in.dir_band_us        = csr_write_data[9:0];
            CSR_DIR_CHANGE_MAX_PCT: cfg_in.dir_change_max_pct = csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_direction      <= 1'b0;
         cfg_ff.loss_timeout_ms    <= 10'd200;
         cfg_ff.step_ms            <= 8'd10;
         cfg_ff.punch_pct          <= 7'd95;
         cfg_ff.dir_mid_us         <= 12'd1500;
         cfg_ff.dir_band_us        <= 10'd120;
         cfg_ff.dir_change_max_pct <= 7'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/rctr_engine.sv =====
// Motor state registers and the per-word update: stores pulse widths,
// runs failsafe, ramp and direction logic on ticks. Depends on rctr_pkg.
module rctr_engine #(
   parameter int TIMER_BITS = rctr_pkg::RCTR_TIMER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rctr_pkg::rctr_cfg_type cfg,
   input  logic                   fire,
   input  logic [1:0]             op,
   input  logic [15:0]            pulse_width_us,
   output rctr_pkg::rctr_rsp_type rsp
);
   import rctr_pkg::*;

   localparam int CMP_W = (TIMER_BITS > FAILSAFE_W) ? TIMER_BITS : FAILSAFE_W;

   logic [11:0]           thr_w_ff, thr_w_in;
   logic [11:0]           dir_w_ff, dir_w_in;
   logic [TIMER_BITS-1:0] since_pulse_ff, since_pulse_in;
   logic [TIMER_BITS-1:0] since_step_ff, since_step_in;
   logic [6:0]            duty_ff, duty_in;
   logic                  dir_ff, dir_in;
   logic                  en_ff, en_in;
   logic                  run_ff, run_in;

   logic                  width_ok;
   logic                  fs;
   logic                  want;
   logic [6:0]            target;
   logic [12:0]           band_hi;
   logic [12:0]           w_plus_hyst;
   logic [TIMER_BITS-1:0] step_cnt;

   always_comb begin
      thr_w_in       = thr_w_ff;
      dir_w_in       = dir_w_ff;
      since_pulse_in = since_pulse_ff;
      since_step_in  = since_step_ff;
      duty_in        = duty_ff;
      dir_in         = dir_ff;
      en_in          = en_ff;
      run_in         = run_ff;
      fs             = 1'b0;
      want           = dir_ff;
      step_cnt       = since_step_ff;
      width_ok       = (pulse_width_us >= WIDTH_MIN) && (pulse_width_us <= WIDTH_MAX);
      target         = target_of(thr_w_ff);
      band_hi        = 13'(cfg.dir_mid_us) + 13'(cfg.dir_band_us);
      w_plus_hyst    = 13'(dir_w_ff) + 13'(cfg.dir_band_us);
      case (op)
         OP_THROTTLE: begin
            if (width_ok) begin
               thr_w_in       = pulse_width_us[11:0];
               since_pulse_in = '0;
            end
         end
         OP_DIRECTION: begin
            if (width_ok) begin
               dir_w_in = pulse_width_us[11:0];
            end
         end
         OP_TICK: begin
            if (CMP_W'(since_pulse_ff) > CMP_W'(cfg.loss_timeout_ms)) begin
               duty_in = 7'd0;
               en_in   = 1'b0;
               run_in  = 1'b0;
               fs      = 1'b1;
            end else begin
               if (cfg.use_direction) begin
                  if (13'(dir_w_ff) > band_hi) begin
                     want = 1'b1;
                  end else if (w_plus_hyst < 13'(cfg.dir_mid_us)) begin
                     want = 1'b0;
                  end
                  if ((want != dir_ff) && (duty_ff < cfg.dir_change_max_pct)) begin
                     dir_in = want;
                  end
               end else begin
                  dir_in = 1'b1;
               end
               if (CMP_W'(since_step_ff) >= CMP_W'(cfg.step_ms)) begin
                  step_cnt = '0;
                  if (target >= cfg.punch_pct) begin
                     duty_in = PCT_FULL;
                     en_in   = 1'b1;
                     run_in  = 1'b1;
                  end else if (duty_ff < target) begin
                     duty_in = duty_ff + RAMP_STEP;
                     en_in   = 1'b1;
                     run_in  = 1'b1;
                  end else if (duty_ff > target) begin
                     duty_in = (duty_ff > RAMP_STEP) ? duty_ff - RAMP_STEP : 7'd0;
                     if (duty_ff <= RAMP_STEP) begin
                        en_in  = 1'b0;
                        run_in = 1'b0;
                     end
                  end
               end
            end
            // advance both timers, saturating
            if (since_pulse_ff != '1) begin
               since_pulse_in = since_pulse_ff + 1'b1;
            end
            since_step_in = (step_cnt != '1) ? step_cnt + 1'b1 : step_cnt;
         end
         default: ;
      endcase

      rsp.pwm_duty        = pwm_of(duty_in);
      rsp.motor_enable    = en_in;
      rsp.dir_cw          = dir_in;
      rsp.duty_pct        = duty_in;
      rsp.target_pct      = target_of(thr_w_in);
      rsp.running         = run_in;
      rsp.failsafe_active = fs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_w_ff       <= WIDTH_RESET;
         dir_w_ff       <= WIDTH_RESET;
         since_pulse_ff <= '0;
         since_step_ff  <= '0;
         duty_ff        <= 7'd0;
         dir_ff         <= 1'b1;
         en_ff          <= 1'b1;
         run_ff         <= 1'b0;
      end else if (fire) begin
         thr_w_ff       <= thr_w_in;
         dir_w_ff       <= dir_w_in;
         since_pulse_ff <= since_pulse_in;
         since_step_ff  <= since_step_in;
         duty_ff        <= duty_in;
         dir_ff         <= dir_in;
         en_ff          <= en_in;
         run_ff         <= run_in;
      end
   end

endmodule

// ===== design/rc_throttle_ramp_motor_control_top.sv =====
// Top level of the RC throttle slew limiter with failsafe.
// Depends on rctr_pkg, rctr_cfg_regs, rctr_engine and the assertion header.
//
// Usage:
//   req_ channel: one word per tick (op 0), throttle pulse (op 1) or
//   direction pulse (op 2), with the pulse width in microseconds.
//   rsp_ channel: one result word per request word, in order, carrying
//   PWM duty, enable, direction, duty and target percent, run state and
//   the failsafe flag.
//   csr_ port: single-cycle writes to the seven settings, taken any time
//   but meant for idle periods.
// Path: an accepted word is held in the input register, and its result is
// loaded into the output register once that register is empty or being read.
// Throughput: one word per cycle while rsp_stall stays low; the motor state
// registers update as the word moves from the input to the output register.
// Reset: synchronous; settings and motor state return to their defaults
// and both channels empty.
// Stall: a stalled result holds in the output register; one more word
// waits in the input register, then req_stall rises.
module rc_throttle_ramp_motor_control_top #(
   parameter int TIMER_BITS = rctr_pkg::RCTR_TIMER_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [rctr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rctr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [15:0]                      req_pulse_width_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_pwm_duty,
   output logic                             rsp_motor_enable,
   output logic                             rsp_dir_cw,
   output logic [6:0]                       rsp_duty_pct,
   output logic [6:0]                       rsp_target_pct,
   output logic                             rsp_running,
   output logic                             rsp_failsafe_active
);
   import rctr_pkg::*;

   `include "rc_throttle_ramp_motor_control_top_assert.svh"

   rctr_cfg_type cfg;
   rctr_rsp_type rsp_next;
   rctr_rsp_type rsp_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [15:0] s1_width_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        take;
   logic        fire;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign fire      = s1_valid_ff && advance;

   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   rctr_cfg_regs u_cfg (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   rctr_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .fire           (fire),
      .op             (s1_op_ff),
      .pulse_width_us (s1_width_ff),
      .rsp            (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff    <= req_op;
         s1_width_ff <= req_pulse_width_us;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pwm_duty        = rsp_ff.pwm_duty;
   assign rsp_motor_enable    = rsp_ff.motor_enable;
   assign rsp_dir_cw          = rsp_ff.dir_cw;
   assign rsp_duty_pct        = rsp_ff.duty_pct;
   assign rsp_target_pct      = rsp_ff.target_pct;
   assign rsp_running         = rsp_ff.running;
   assign rsp_failsafe_active = rsp_ff.failsafe_active;

   `RCTR_ASSERT_IMPL(a_failsafe_stops, rsp_valid && rsp_failsafe_active,
      (rsp_duty_pct == 7'd0) && !rsp_motor_enable && !rsp_running,
      "failsafe result with motor still driven")
   `RCTR_ASSERT_IMPL(a_run_enabled, rsp_valid && rsp_running, rsp_motor_enable,
      "running with enable low")
   `RCTR_ASSERT_IFF(a_pwm_zero, rsp_valid, rsp_pwm_duty == 8'd0, rsp_duty_pct == 7'd0,
      "pwm duty and duty percent disagree on zero")

endmodule

// ===== tb/sv/rctr_checker.sv =====
// Checker for the throttle ramp block: watches the settings port and both word channels,
// predicts each result word from its own motor model and compares it field by field.
// Depends on rctr_pkg for the codes, constants and word types.
module rctr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [rctr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rctr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [15:0]                      req_pulse_width_us,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [7:0]                       rsp_pwm_duty,
   input  logic                             rsp_motor_enable,
   input  logic                             rsp_dir_cw,
   input  logic [6:0]                       rsp_duty_pct,
   input  logic [6:0]                       rsp_target_pct,
   input  logic                             rsp_running,
   input  logic                             rsp_failsafe_active,
   output int                               mismatches,
   output int                               pending
);
   import rctr_pkg::*;

   localparam logic [10:0] COUNT_MAX = '1;

   rctr_cfg_type cfg;
   logic [11:0]  thr_width;
   logic [11:0]  dir_width;
   logic [10:0]  since_pulse;
   logic [10:0]  since_step;
   logic [6:0]   duty;
   logic         cw;
   logic         enable;
   logic         run;
   rctr_rsp_type motor_q[$];

   initial mismatches = 0;

   function automatic logic [6:0] throttle_pct(input logic [11:0] w);
      if (w <= MAP_LOW) return 7'd0;
      if (w >= MAP_HIGH) return PCT_FULL;
      return 7'((w - MAP_LOW) / 10);
   endfunction

   function automatic logic [7:0] duty_to_pwm(input logic [6:0] pct);
      int p;
      p = (pct > PCT_FULL) ? 100 : int'(pct);
      return 8'(p * 255 / 100);
   endfunction

   function automatic rctr_rsp_type motor_step(input logic [1:0] op, input logic [15:0] w);
      logic         pulse_ok;
      logic         trip;
      logic         want;
      logic [6:0]   tgt;
      int           hi;
      int           lo;
      rctr_rsp_type r;
      pulse_ok = (w >= WIDTH_MIN) && (w <= WIDTH_MAX);
      trip = 1'b0;
      case (op)
         OP_THROTTLE: begin
            if (pulse_ok) begin
               thr_width = w[11:0];
               since_pulse = '0;
            end
         end
         OP_DIRECTION: begin
            if (pulse_ok) dir_width = w[11:0];
         end
         OP_TICK: begin
            tgt = throttle_pct(thr_width);
            if (since_pulse > cfg.loss_timeout_ms) begin
               duty = '0;
               enable = 1'b0;
               run = 1'b0;
               trip = 1'b1;
            end else begin
               if (cfg.use_direction) begin
                  hi = int'(cfg.dir_mid_us) + int'(cfg.dir_band_us);
                  lo = int'(cfg.dir_mid_us) - int'(cfg.dir_band_us);
                  want = cw;
                  if (int'(dir_width) > hi) want = 1'b1;
                  else if (int'(dir_width) < lo) want = 1'b0;
                  if (want != cw && duty < cfg.dir_change_max_pct) cw = want;
               end else begin
                  cw = 1'b1;
               end
               if (since_step >= cfg.step_ms) begin
                  since_step = '0;
                  if (tgt >= cfg.punch_pct) begin
                     duty = PCT_FULL;
                     enable = 1'b1;
                     run = 1'b1;
                  end else if (duty < tgt) begin
                     duty = duty + RAMP_STEP;
                     enable = 1'b1;
                     run = 1'b1;
                  end else if (duty > tgt) begin
                     duty = (duty > RAMP_STEP) ? duty - RAMP_STEP : '0;
                     if (duty == '0) begin
                        enable = 1'b0;
                        run = 1'b0;
                     end
                  end
               end
            end
            if (since_pulse != COUNT_MAX) since_pulse = since_pulse + 1'b1;
            if (since_step != COUNT_MAX) since_step = since_step + 1'b1;
         end
         default: ;
      endcase
      r.pwm_duty = duty_to_pwm(duty);
      r.motor_enable = enable;
      r.dir_cw = cw;
      r.duty_pct = duty;
      r.target_pct = throttle_pct(thr_width);
      r.running = run;
      r.failsafe_active = trip;
      return r;
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0d actual %0d", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rctr_rsp_type want_w;
      rctr_rsp_type got_w;
      if (reset) begin
         cfg.use_direction = 1'b0;
         cfg.loss_timeout_ms = 10'd200;
         cfg.step_ms = 8'd10;
         cfg.punch_pct = 7'd95;
         cfg.dir_mid_us = 12'd1500;
         cfg.dir_band_us = 10'd120;
         cfg.dir_change_max_pct = 7'd10;
         thr_width = WIDTH_RESET;
         dir_width = WIDTH_RESET;
         since_pulse = '0;
         since_step = '0;
         duty = '0;
         cw = 1'b1;
         enable = 1'b1;
         run = 1'b0;
         motor_q.delete();
         pending = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_USE_DIRECTION:      cfg.use_direction = csr_write_data[0];
               CSR_LOSS_TIMEOUT_MS:    cfg.loss_timeout_ms = csr_write_data[9:0];
               CSR_STEP_MS:            cfg.step_ms = csr_write_data[7:0];
               CSR_PUNCH_PCT:          cfg.punch_pct = csr_write_data[6:0];
               CSR_DIR_MID_US:         cfg.dir_mid_us = csr_write_data[11:0];
               CSR_DIR_BAND_US:        cfg.dir_band_us = csr_write_data[9:0];
               CSR_DIR_CHANGE_MAX_PCT: cfg.dir_change_max_pct = csr_write_data[6:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got_w = {rsp_pwm_duty, rsp_motor_enable, rsp_dir_cw, rsp_duty_pct,
                     rsp_target_pct, rsp_running, rsp_failsafe_active};
            if (motor_q.size() == 0) begin
               $error("result word with no prediction waiting");
               mismatches++;
            end else begin
               want_w = motor_q.pop_front();
               check_field("pwm_duty", want_w.pwm_duty, got_w.pwm_duty);
               check_field("motor_enable", want_w.motor_enable, got_w.motor_enable);
               check_field("dir_cw", want_w.dir_cw, got_w.dir_cw);
               check_field("duty_pct", want_w.duty_pct, got_w.duty_pct);
               check_field("target_pct", want_w.target_pct, got_w.target_pct);
               check_field("running", want_w.running, got_w.running);
               check_field("failsafe_active", want_w.failsafe_active, got_w.failsafe_active);
            end
         end
         if (req_valid && !req_stall)
            motor_q.push_back(motor_step(req_op, req_pulse_width_us));
         pending = motor_q.size();
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the throttle ramp testbench: clock, reset, settings writes and word traffic
// with random gaps and stalls; the verdict comes from rctr_checker.
// Depends on rctr_pkg, rctr_checker and rc_throttle_ramp_motor_control_top.
module tb;
   import rctr_pkg::*;

   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_op;
   logic [15:0]            req_pulse_width_us;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_pwm_duty;
   logic                   rsp_motor_enable;
   logic                   rsp_dir_cw;
   logic [6:0]             rsp_duty_pct;
   logic [6:0]             rsp_target_pct;
   logic                   rsp_running;
   logic                   rsp_failsafe_active;
   int                     mismatches;
   int                     pending;
   int                     cycles = 0;
   bit                     no_idle = 1'b0;
   bit                     hold_rsp = 1'b0;

   rc_throttle_ramp_motor_control_top dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_pulse_width_us(req_pulse_width_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pwm_duty(rsp_pwm_duty),
      .rsp_motor_enable(rsp_motor_enable), .rsp_dir_cw(rsp_dir_cw),
      .rsp_duty_pct(rsp_duty_pct), .rsp_target_pct(rsp_target_pct),
      .rsp_running(rsp_running), .rsp_failsafe_active(rsp_failsafe_active)
   );

   rctr_checker chk (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_pulse_width_us(req_pulse_width_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pwm_duty(rsp_pwm_duty),
      .rsp_motor_enable(rsp_motor_enable), .rsp_dir_cw(rsp_dir_cw),
      .rsp_duty_pct(rsp_duty_pct), .rsp_target_pct(rsp_target_pct),
      .rsp_running(rsp_running), .rsp_failsafe_active(rsp_failsafe_active),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stall the result channel per word; long hold-off on request
   initial begin : rsp_side
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(16, 0);
         if (hold_rsp) begin
            hold = 60;
            hold_rsp = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [15:0] w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(16, 0);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_pulse_width_us = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid and wait until every predicted word has come back
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = CSR_DATA_W'(value);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_settings(input int use_dir, input int fs, input int step,
                                input int punch, input int mid, input int hyst,
                                input int chg);
      write_reg(CSR_USE_DIRECTION, use_dir);
      write_reg(CSR_LOSS_TIMEOUT_MS, fs);
      write_reg(CSR_STEP_MS, step);
      write_reg(CSR_PUNCH_PCT, punch);
      write_reg(CSR_DIR_MID_US, mid);
      write_reg(CSR_DIR_BAND_US, hyst);
      write_reg(CSR_DIR_CHANGE_MAX_PCT, chg);
   endtask

   function automatic int pick(input int lo, input int hi, input int typ_lo, input int typ_hi);
      int r;
      r = $urandom_range(7, 0);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return $urandom_range(typ_hi, typ_lo);
   endfunction

   function automatic logic [15:0] draw_width();
      int edges[8] = '{799, 800, 1000, 1001, 2000, 2001, 2200, 2201};
      int r;
      r = $urandom_range(15, 0);
      case (r)
         0: return 16'($urandom_range(65535, 0));
         1: return 16'($urandom_range(799, 0));
         2: return 16'($urandom_range(65535, 2201));
         3: return 16'(edges[$urandom_range(7, 0)]);
         default: return 16'($urandom_range(2200, 800));
      endcase
   endfunction

   task automatic random_word(input int thr_pct);
      int r;
      r = $urandom_range(99, 0);
      if (r < thr_pct) send_word(OP_THROTTLE, draw_width());
      else if (r < thr_pct + 15) send_word(OP_DIRECTION, draw_width());
      else if (r < thr_pct + 19) send_word(OP_UNDEFINED, 16'($urandom_range(65535, 0)));
      else send_word(OP_TICK, 16'($urandom_range(65535, 0)));
   endtask

   initial begin : stimulus
      int rates[3] = '{1, 5, 20};
      int thr_pct;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_pulse_width_us = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      send_word(OP_TICK, 16'd0);
      send_word(OP_THROTTLE, 16'd2200);
      send_word(OP_THROTTLE, 16'd2201);
      send_word(OP_THROTTLE, 16'd799);
      send_word(OP_THROTTLE, 16'd800);
      send_word(OP_DIRECTION, 16'hFFFF);
      send_word(OP_UNDEFINED, 16'hFFFF);
      send_word(OP_UNDEFINED, 16'd0);
      send_word(OP_DIRECTION, 16'd0);
      drain();
      load_settings(1, 0, 0, 101, 2200, 700, 101);
      send_word(OP_THROTTLE, 16'd2000);
      send_word(OP_TICK, 16'd0);
      send_word(OP_TICK, 16'hFFFF);
      send_word(OP_DIRECTION, 16'd800);
      send_word(OP_THROTTLE, 16'd1030);
      send_word(OP_TICK, 16'd0);
      drain();
      write_reg(CSR_LOSS_TIMEOUT_MS, 1023);
      send_word(OP_TICK, 16'd0);
      send_word(OP_TICK, 16'd0);
      send_word(OP_TICK, 16'd0);
      drain();
      load_settings(1, 1023, 1, 0, 800, 0, 0);
      send_word(OP_DIRECTION, 16'd2200);
      send_word(OP_TICK, 16'd0);
      send_word(OP_THROTTLE, 16'd1000);
      drain();
      write_reg(CSR_PUNCH_PCT, 95);
      write_reg(CSR_DIR_CHANGE_MAX_PCT, 101);
      send_word(OP_TICK, 16'd0);
      send_word(OP_TICK, 16'd0);
      send_word(OP_THROTTLE, 16'hFFFF);
      send_word(OP_TICK, 16'd0);
      drain();

      // hold the result side off while words keep coming
      hold_rsp = 1'b1;
      no_idle = 1'b1;
      repeat (12) send_word(OP_TICK, 16'($urandom_range(65535, 0)));
      drain();

      // long tick run into failsafe
      load_settings(1, 150, 5, 95, 1500, 120, 10);
      send_word(OP_THROTTLE, 16'd1800);
      repeat (200) send_word(OP_TICK, 16'd0);
      drain();
      no_idle = 1'b0;

      for (int phase = 0; phase < 7; phase++) begin
         load_settings($urandom_range(1, 0), pick(0, 1023, 2, 40), pick(0, 255, 1, 6),
                       pick(0, 101, 50, 100), pick(800, 2200, 1300, 1700),
                       pick(0, 700, 0, 200), pick(0, 101, 0, 40));
         no_idle = (phase % 3 == 2);
         thr_pct = rates[$urandom_range(2, 0)];
         repeat (70) random_word(thr_pct);
         drain();
      end
      no_idle = 1'b0;
      repeat (8) @(negedge clock);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
